### design/bmpw_pkg.sv
// bmpw_pkg: shared types and constants of the bmp window address generator
package bmpw_pkg;

  // configuration register indices
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_DATA_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEFT       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_TOP        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HEIGHT     = 3'd6;

  // field widths
  localparam int CFG_DATA_W = 32;
  localparam int IMG_W_W    = 13;
  localparam int IMG_H_W    = 14;
  localparam int ADDR_W     = 32;
  localparam int POS_W      = 12;
  localparam int WIN_SZ_W   = 13;
  localparam int INDEX_W    = 26;
  localparam int STRIDE_W   = 15;

  // code of the final colour byte of a pixel
  localparam logic [1:0] COLOR_LAST = 2'd2;

  // reset value of the pixel data offset register
  localparam logic [ADDR_W-1:0] OFFSET_RESET = 32'd54;

  typedef struct packed {
    logic [IMG_W_W-1:0]        frame_width;
    logic signed [IMG_H_W-1:0] frame_height;
    logic [ADDR_W-1:0]         pixel_data_offset;
    logic [POS_W-1:0]          window_left;
    logic [POS_W-1:0]          window_top;
    logic [WIN_SZ_W-1:0]       window_width;
    logic [WIN_SZ_W-1:0]       window_height;
  } cfg_regs_t;

endpackage

### design/bmpw_if.sv
// bmpw_if: request, result and configuration channel interfaces
interface bmpw_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface bmpw_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmpw_pkg::ADDR_W-1:0]  source_address;
  logic [bmpw_pkg::INDEX_W-1:0] result_index;
  logic                         last;
  modport source (output valid, output source_address, output result_index, output last,
                  input ready);
  modport sink (input valid, input source_address, input result_index, input last,
                output ready);
endinterface

interface bmpw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmpw_pkg::REG_IDX_W-1:0]  index;
  logic [bmpw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/bmpw_walk.sv
// bmpw_walk: window walk counters, restart handling and first pipeline stage
module bmpw_walk #(
  parameter int MAX_DIM = 4096,
  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int SZ_W  = ($clog2(MAX_DIM + 1) > bmpw_pkg::WIN_SZ_W) ?
                         $clog2(MAX_DIM + 1) : bmpw_pkg::WIN_SZ_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bmpw_in_if.sink                      in_req,
  input  bmpw_pkg::cfg_regs_t          cfg,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output logic [CNT_W-1:0]             s1_row,
  output logic [CNT_W-1:0]             s1_col,
  output logic [1:0]                   s1_color,
  output logic [bmpw_pkg::INDEX_W-1:0] s1_index,
  output logic                         s1_last
);

  logic [1:0]                   color_r, color_nxt;
  logic [CNT_W-1:0]             col_r, col_nxt;
  logic [CNT_W-1:0]             row_r, row_nxt;
  logic [bmpw_pkg::INDEX_W-1:0] count_r, count_nxt;
  logic                         v1_r;
  logic [CNT_W-1:0]             row1_r, col1_r;
  logic [1:0]                   color1_r;
  logic [bmpw_pkg::INDEX_W-1:0] index1_r;
  logic                         last1_r;

  logic                         accept;
  logic [SZ_W-1:0]              ww_raw, wh_raw, ww, wh;
  logic [1:0]                   color_cur;
  logic [CNT_W-1:0]             col_cur, row_cur;
  logic [bmpw_pkg::INDEX_W-1:0] count_cur;
  logic                         col_end, row_end, last;

  // stage one takes a request when empty or when it drains
  assign in_req.ready = !v1_r || s1_ready;
  assign accept       = in_req.valid && in_req.ready;

  // window size, zero acts as one, saturated at the maximum
  assign ww_raw = SZ_W'(cfg.window_width);
  assign wh_raw = SZ_W'(cfg.window_height);
  assign ww = (ww_raw == '0) ? SZ_W'(1) : (ww_raw > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : ww_raw;
  assign wh = (wh_raw == '0) ? SZ_W'(1) : (wh_raw > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : wh_raw;

  // position of this request, back at the origin on restart
  assign color_cur = in_req.restart ? 2'd0 : color_r;
  assign col_cur   = in_req.restart ? '0 : col_r;
  assign row_cur   = in_req.restart ? '0 : row_r;
  assign count_cur = in_req.restart ? '0 : count_r;

  assign col_end = (SZ_W'(col_cur) + SZ_W'(1)) >= ww;
  assign row_end = (SZ_W'(row_cur) + SZ_W'(1)) >= wh;
  assign last    = (color_cur == bmpw_pkg::COLOR_LAST) && col_end && row_end;

  // advance colour byte, column, row; wrap to origin after the final byte
  always_comb begin
    color_nxt = color_cur;
    col_nxt   = col_cur;
    row_nxt   = row_cur;
    count_nxt = count_cur + bmpw_pkg::INDEX_W'(1);
    if (last) begin
      color_nxt = 2'd0;
      col_nxt   = '0;
      row_nxt   = '0;
      count_nxt = '0;
    end else if (color_cur != bmpw_pkg::COLOR_LAST) begin
      color_nxt = color_cur + 2'd1;
    end else begin
      color_nxt = 2'd0;
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_cur + CNT_W'(1);
      end else begin
        col_nxt = col_cur + CNT_W'(1);
      end
    end
  end

  // walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= 2'd0;
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
    end else if (accept) begin
      color_r <= color_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
    end
  end

  // stage one valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (accept) begin
      v1_r <= 1'b1;
    end else if (s1_ready) begin
      v1_r <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      row1_r   <= row_cur;
      col1_r   <= col_cur;
      color1_r <= color_cur;
      index1_r <= count_cur;
      last1_r  <= last;
    end
  end

  assign s1_valid = v1_r;
  assign s1_row   = row1_r;
  assign s1_col   = col1_r;
  assign s1_color = color1_r;
  assign s1_index = index1_r;
  assign s1_last  = last1_r;

endmodule

### design/bmpw_addr.sv
// bmpw_addr: row base multiply stage and address sum output stage
module bmpw_addr #(
  parameter int MAX_DIM = 4096,
  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int ROW_W = ((CNT_W > bmpw_pkg::POS_W) ? CNT_W : bmpw_pkg::POS_W) + 1,
  localparam int COL_W = ROW_W,
  localparam int RF_W  = ((ROW_W > bmpw_pkg::IMG_H_W) ? ROW_W : bmpw_pkg::IMG_H_W) + 1,
  localparam int PR_W  = RF_W + bmpw_pkg::STRIDE_W + 1,
  localparam int CT_W  = COL_W + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bmpw_pkg::cfg_regs_t          cfg,
  input  logic                         s1_valid,
  output logic                         s1_ready,
  input  logic [CNT_W-1:0]             s1_row,
  input  logic [CNT_W-1:0]             s1_col,
  input  logic [1:0]                   s1_color,
  input  logic [bmpw_pkg::INDEX_W-1:0] s1_index,
  input  logic                         s1_last,
  bmpw_out_if.source                   out_res
);

  logic                          v2_r, v3_r;
  logic [bmpw_pkg::ADDR_W-1:0]   base2_r;
  logic [CT_W-1:0]               ct2_r;
  logic [bmpw_pkg::INDEX_W-1:0]  index2_r, index3_r;
  logic                          last2_r, last3_r;
  logic [bmpw_pkg::ADDR_W-1:0]   addr3_r;

  logic                          s2_ready, s3_ready;
  logic [ROW_W-1:0]              row;
  logic [COL_W-1:0]              col_px;
  logic [bmpw_pkg::STRIDE_W:0]   stride_sum;
  logic [bmpw_pkg::STRIDE_W-1:0] stride;
  logic signed [RF_W-1:0]        h_s, row_s, factor;
  logic signed [bmpw_pkg::STRIDE_W:0] stride_s;
  logic signed [PR_W-1:0]        prod;
  logic [CT_W-1:0]               ct;

  // stage readiness, back to front
  assign s3_ready = !v3_r || out_res.ready;
  assign s2_ready = !v2_r || s3_ready;
  assign s1_ready = s2_ready;

  // source row, flipped for bottom-up images
  assign row   = ROW_W'(cfg.window_top) + ROW_W'(s1_row);
  assign h_s   = RF_W'(cfg.frame_height);
  assign row_s = RF_W'(row);
  assign factor = cfg.frame_height[bmpw_pkg::IMG_H_W-1] ? row_s :
                  (h_s - row_s - RF_W'(1));

  // row stride, three bytes a pixel, rounded up to a multiple of four bytes
  assign stride_sum = (bmpw_pkg::STRIDE_W + 1)'(cfg.frame_width)
                    + (bmpw_pkg::STRIDE_W + 1)'({cfg.frame_width, 1'b0})
                    + (bmpw_pkg::STRIDE_W + 1)'(3);
  assign stride     = {stride_sum[bmpw_pkg::STRIDE_W-1:2], 2'b00};
  assign stride_s   = {1'b0, stride};
  assign prod       = factor * stride_s;

  // byte offset within the row
  assign col_px = COL_W'(cfg.window_left) + COL_W'(s1_col);
  assign ct     = CT_W'({col_px, 1'b0}) + CT_W'(col_px) + CT_W'(s1_color);

  // stage two: row base and column term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_ready) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      base2_r  <= bmpw_pkg::ADDR_W'(prod);
      ct2_r    <= ct;
      index2_r <= s1_index;
      last2_r  <= s1_last;
    end
  end

  // stage three: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_ready) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && v2_r) begin
      addr3_r  <= cfg.pixel_data_offset + base2_r + bmpw_pkg::ADDR_W'(ct2_r);
      index3_r <= index2_r;
      last3_r  <= last2_r;
    end
  end

  assign out_res.valid          = v3_r;
  assign out_res.source_address = addr3_r;
  assign out_res.result_index   = index3_r;
  assign out_res.last           = last3_r;

endmodule

### design/bmp_window_address_generator_unit.sv
// bmp_window_address_generator_unit: top level of the bmp window address generator
//
//   channel  | dir | payload                                  | transfer
//   ---------+-----+------------------------------------------+-------------------
//   in_req   | in  | restart                                  | valid && ready
//   out_res  | out | source_address, result_index, last       | valid && ready
//   cfg_wr   | in  | index (register number), data            | valid && ready
//
// one request a cycle unless a stalled result holds the pipeline; each result passes through the registers of
// the walk stage, row multiply stage and address sum stage, in that order
// reset (rst_n low, synchronous) loads register defaults and puts the walk at the origin
// a stalled result holds the pipeline; free stages keep taking requests
// cfg_wr is always ready
module bmp_window_address_generator_unit #(
  parameter int MAX_DIM = 4096,
  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  bmpw_in_if.sink    in_req,
  bmpw_out_if.source out_res,
  bmpw_cfg_if.sink   cfg_wr
);

  bmpw_pkg::cfg_regs_t          cfg_r;
  logic                         s1_valid, s1_ready;
  logic [CNT_W-1:0]             s1_row, s1_col;
  logic [1:0]                   s1_color;
  logic [bmpw_pkg::INDEX_W-1:0] s1_index;
  logic                         s1_last;

  // configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width       <= bmpw_pkg::IMG_W_W'(1);
      cfg_r.frame_height      <= bmpw_pkg::IMG_H_W'(1);
      cfg_r.pixel_data_offset <= bmpw_pkg::OFFSET_RESET;
      cfg_r.window_left       <= '0;
      cfg_r.window_top        <= '0;
      cfg_r.window_width      <= bmpw_pkg::WIN_SZ_W'(1);
      cfg_r.window_height     <= bmpw_pkg::WIN_SZ_W'(1);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        bmpw_pkg::REG_IMAGE_WIDTH: begin
          cfg_r.frame_width <= cfg_wr.data[bmpw_pkg::IMG_W_W-1:0];
        end
        bmpw_pkg::REG_IMAGE_HEIGHT: begin
          cfg_r.frame_height <= cfg_wr.data[bmpw_pkg::IMG_H_W-1:0];
        end
        bmpw_pkg::REG_PIXEL_DATA_OFFSET: begin
          cfg_r.pixel_data_offset <= cfg_wr.data[bmpw_pkg::ADDR_W-1:0];
        end
        bmpw_pkg::REG_WINDOW_LEFT: begin
          cfg_r.window_left <= cfg_wr.data[bmpw_pkg::POS_W-1:0];
        end
        bmpw_pkg::REG_WINDOW_TOP: begin
          cfg_r.window_top <= cfg_wr.data[bmpw_pkg::POS_W-1:0];
        end
        bmpw_pkg::REG_WINDOW_WIDTH: begin
          cfg_r.window_width <= cfg_wr.data[bmpw_pkg::WIN_SZ_W-1:0];
        end
        bmpw_pkg::REG_WINDOW_HEIGHT: begin
          cfg_r.window_height <= cfg_wr.data[bmpw_pkg::WIN_SZ_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // walk counters and first stage
  bmpw_walk #(.MAX_DIM(MAX_DIM)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .s1_color (s1_color),
    .s1_index (s1_index),
    .s1_last  (s1_last)
  );

  // address arithmetic and result register
  bmpw_addr #(.MAX_DIM(MAX_DIM)) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .s1_color (s1_color),
    .s1_index (s1_index),
    .s1_last  (s1_last),
    .out_res  (out_res)
  );

endmodule

### tb/tb_bmp_window_address_generator_unit.sv
// testbench of the bmp window address generator: predicted byte reads checked against the block
module tb_bmp_window_address_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SIZE = 4096;
  localparam int SHOWN_MAX = 20;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]  source_address;
    logic [INDEX_W-1:0] result_index;
    logic               last;
  } byte_read_t;

  logic clk = 1'b0;
  logic rst_n;

  bmpw_in_if  in_req();
  bmpw_out_if out_res();
  bmpw_cfg_if cfg_wr();

  bmp_window_address_generator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  // shadow registers and walk position of the predictor
  cfg_regs_t          shadow_cfg;
  logic [1:0]         walk_color;
  logic [POS_W-1:0]   walk_col;
  logic [POS_W-1:0]   walk_row;
  logic [INDEX_W-1:0] walk_count;

  byte_read_t expected_reads[$];
  byte_read_t oldest_read;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_len = 0;
  int stall_seq = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int reads_checked = 0;
  int windows_done = 0;
  int requests_sent = 0;
  int reg_writes = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // window size as the walk sees it: zero acts as one, large sizes saturate
  function automatic logic [WIN_SZ_W-1:0] effective_size(input logic [WIN_SZ_W-1:0] v);
    if (v == '0) return WIN_SZ_W'(1);
    if (32'(v) > MAX_SIZE) return WIN_SZ_W'(MAX_SIZE);
    return v;
  endfunction

  function automatic void walk_home();
    walk_color = '0;
    walk_col   = '0;
    walk_row   = '0;
    walk_count = '0;
  endfunction

  function automatic void reset_shadow();
    shadow_cfg.frame_width       = IMG_W_W'(1);
    shadow_cfg.frame_height      = IMG_H_W'(1);
    shadow_cfg.pixel_data_offset = OFFSET_RESET;
    shadow_cfg.window_left       = '0;
    shadow_cfg.window_top        = '0;
    shadow_cfg.window_width      = WIN_SZ_W'(1);
    shadow_cfg.window_height     = WIN_SZ_W'(1);
    walk_home();
  endfunction

  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH:       shadow_cfg.frame_width       = d[IMG_W_W-1:0];
      REG_IMAGE_HEIGHT:      shadow_cfg.frame_height      = d[IMG_H_W-1:0];
      REG_PIXEL_DATA_OFFSET: shadow_cfg.pixel_data_offset = d[ADDR_W-1:0];
      REG_WINDOW_LEFT:       shadow_cfg.window_left       = d[POS_W-1:0];
      REG_WINDOW_TOP:        shadow_cfg.window_top        = d[POS_W-1:0];
      REG_WINDOW_WIDTH:      shadow_cfg.window_width      = d[WIN_SZ_W-1:0];
      REG_WINDOW_HEIGHT:     shadow_cfg.window_height     = d[WIN_SZ_W-1:0];
      default: ;
    endcase
  endfunction

  // address, destination index and last mark of the next byte, then advance the walk
  function automatic byte_read_t next_read(input logic restart);
    byte_read_t r;
    logic [ADDR_W-1:0] stride;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] base;
    logic col_end;
    logic row_end;
    if (restart) walk_home();
    stride = (32'(shadow_cfg.frame_width) * 32'd3 + 32'd3) & ~32'd3;
    row = 32'(shadow_cfg.window_top) + 32'(walk_row);
    // negative height stores rows top-down, anything else bottom-up
    if (shadow_cfg.frame_height[IMG_H_W-1]) begin
      base = shadow_cfg.pixel_data_offset + row * stride;
    end else begin
      base = shadow_cfg.pixel_data_offset
             + (32'($unsigned(shadow_cfg.frame_height)) - 32'd1 - row) * stride;
    end
    r.source_address = base + (32'(shadow_cfg.window_left) + 32'(walk_col)) * 32'd3
                       + 32'(walk_color);
    r.result_index = walk_count;
    col_end = (32'(walk_col) + 32'd1) >= 32'(effective_size(shadow_cfg.window_width));
    row_end = (32'(walk_row) + 32'd1) >= 32'(effective_size(shadow_cfg.window_height));
    r.last = (walk_color == COLOR_LAST) && col_end && row_end;
    if (r.last) begin
      walk_home();
    end else begin
      walk_count = walk_count + INDEX_W'(1);
      if (walk_color != COLOR_LAST) begin
        walk_color = walk_color + 2'd1;
      end else begin
        walk_color = '0;
        if (col_end) begin
          walk_col = '0;
          walk_row = walk_row + POS_W'(1);
        end else begin
          walk_col = walk_col + POS_W'(1);
        end
      end
    end
    return r;
  endfunction

  // one register write, valid dropped on the following falling edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= d;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    apply_reg(idx, d);
    reg_writes++;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  // full register set; noisy puts random junk above each field narrower than the data word
  task automatic load_setup(input logic [IMG_W_W-1:0] w, input logic [IMG_H_W-1:0] h,
                            input logic [ADDR_W-1:0] off, input logic [POS_W-1:0] l,
                            input logic [POS_W-1:0] t, input logic [WIN_SZ_W-1:0] ww,
                            input logic [WIN_SZ_W-1:0] wh, input bit noisy);
    logic [CFG_DATA_W-1:0] hi;
    hi = noisy ? $urandom : '0;
    write_reg(REG_IMAGE_WIDTH, {hi[CFG_DATA_W-1:IMG_W_W], w});
    write_reg(REG_IMAGE_HEIGHT, {hi[CFG_DATA_W-1:IMG_H_W], h});
    write_reg(REG_PIXEL_DATA_OFFSET, off);
    write_reg(REG_WINDOW_LEFT, {hi[CFG_DATA_W-1:POS_W], l});
    write_reg(REG_WINDOW_TOP, {hi[CFG_DATA_W-1:POS_W], t});
    write_reg(REG_WINDOW_WIDTH, {hi[CFG_DATA_W-1:WIN_SZ_W], ww});
    write_reg(REG_WINDOW_HEIGHT, {hi[CFG_DATA_W-1:WIN_SZ_W], wh});
  endtask

  // one request; called and left at a falling edge, valid stays up for a following request
  task automatic offer_request(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.restart <= restart;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    expected_reads.push_back(next_read(restart));
    requests_sent++;
    @(negedge clk);
  endtask

  // stop requesting until every predicted read has come back
  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (expected_reads.size() != 0);
  endtask

  // default registers: 1x1 window at offset 54, wraps after its third byte
  task automatic test_reset_state();
    offer_request(1'b0);
    offer_request(1'b0);
    offer_request(1'b0);
    offer_request(1'b0);
    offer_request(1'b1);
    drain_results();
  endtask

  // extremes of every register, zero sizes, zero height, restart mid-walk
  task automatic test_corner_geometry();
    // top-down image at the far corner, offset wraps at once, zero window height
    load_setup(13'd4096, 14'(-4096), 32'hFFFF_FFFF, 12'd4095, 12'd4095, 13'd2, 13'd0, 1'b0);
    offer_request(1'b1);
    offer_request(1'b0);
    offer_request(1'b1);
    for (int i = 0; i < 5; i++) offer_request(1'b0);
    drain_results();
    // zero height image, zero window width, unused register index
    load_setup(13'd1, 14'd0, 32'd0, 12'd0, 12'd0, 13'd0, 13'd2, 1'b1);
    write_reg(REG_UNUSED, $urandom);
    offer_request(1'b1);
    for (int i = 0; i < 5; i++) offer_request(1'b0);
    drain_results();
    // tallest bottom-up image, widest width field
    load_setup(13'h1FFF, 14'd4096, 32'h8000_0000, 12'd0, 12'd4095, 13'd1, 13'd1, 1'b0);
    offer_request(1'b1);
    for (int i = 0; i < 3; i++) offer_request(1'b0);
    offer_request(1'b1);
    drain_results();
  endtask

  // random geometry, small windows walked through with the odd restart
  task automatic test_random_walks(input int setups, input int per_setup);
    logic restart;
    for (int s = 0; s < setups; s++) begin
      load_setup(13'($urandom_range(1, 4096)), 14'(int'($urandom_range(8192)) - 4096),
                 $urandom, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                 13'($urandom_range(6)), 13'($urandom_range(4)), 1'($urandom_range(1)));
      for (int i = 0; i < per_setup; i++) begin
        // no restart on the first request keeps the walk position from the last setup
        if (i == 0) restart = 1'($urandom_range(1));
        else restart = ($urandom_range(39) == 0);
        offer_request(restart);
      end
      drain_results();
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    stall_len = 200;
    stall_seq++;
    for (int i = 0; i < 40; i++) offer_request(($urandom_range(15) == 0));
    drain_results();
  endtask

  // sizes above the maximum saturate instead of wrapping to a small window
  task automatic test_size_clamping();
    load_setup(13'd4096, 14'd4096, $urandom, 12'd4095, 12'd0, 13'h1001, 13'd1, 1'b0);
    for (int i = 0; i < 30; i++) offer_request(i == 0);
    drain_results();
    load_setup(13'd4096, 14'(-4096), $urandom, 12'd0, 12'd4095, 13'd1, 13'd4097, 1'b0);
    for (int i = 0; i < 30; i++) offer_request(i == 0);
    drain_results();
  endtask

  // result side: random idling plus requested long hold-offs
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        stall_left = stall_len;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("%0t: result with nothing expected: addr=%h index=%0d last=%b",
                   $realtime, out_res.source_address, out_res.result_index, out_res.last);
      end else begin
        oldest_read = expected_reads.pop_front();
        reads_checked++;
        if (oldest_read.last) windows_done++;
        if (out_res.source_address !== oldest_read.source_address ||
            out_res.result_index !== oldest_read.result_index ||
            out_res.last !== oldest_read.last) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: expected addr=%h index=%0d last=%b, got addr=%h index=%0d last=%b",
                     $realtime, oldest_read.source_address, oldest_read.result_index,
                     oldest_read.last, out_res.source_address, out_res.result_index,
                     out_res.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
               expected_reads.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n          = 1'b0;
    in_req.valid   = 1'b0;
    in_req.restart = 1'b0;
    cfg_wr.valid   = 1'b0;
    cfg_wr.index   = '0;
    cfg_wr.data    = '0;
    reset_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 69;
    test_reset_state();
    test_corner_geometry();
    test_random_walks(6, 40);

    send_idle_pct = 69;
    recv_idle_pct = 26;
    test_random_walks(6, 40);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walks(6, 40);
    test_size_clamping();

    drain_results();
    repeat (6) @(negedge clk);

    $display("%0d requests, %0d reads checked, %0d whole windows, %0d register writes",
             requests_sent, reads_checked, windows_done, reg_writes);
    $display("covered top-down, bottom-up and zero-height images, restarts, size clamping, stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
